// ===== src/cfs_pkg.sv =====
// ----------------------------------------------------------------------------
// cfs_pkg
// Shared types, constants and helpers of the camera follow smoother.
// ----------------------------------------------------------------------------
`default_nettype none
package cfs_pkg;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 64;
  localparam int PosW = 32;
  localparam int ZoomW = 24;
  localparam int FactorW = 16;
  localparam int DtW = 12;
  localparam int WeightW = 17;
  localparam int AccW = 40;
  localparam int DvdW = 37;
  localparam int DeadW = 31;

  localparam logic [DtW-1:0] DT_CAP = 12'd3277;
  localparam logic [ZoomW-1:0] ZOOM_FLOOR = 24'd655;
  localparam logic [ZoomW-1:0] ZOOM_RESET = 24'd65536;
  localparam logic [FactorW-1:0] ZOOM_FACTOR_RESET = 16'd1280;
  localparam logic [WeightW-1:0] ONE_Q16 = 17'h10000;
  localparam logic [DvdW-1:0] DVD_HALF_W = 37'h10_0000_0000;
  localparam logic [DvdW-1:0] DVD_HALF_H = 37'h09_0000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FOLLOW_FACTOR = 3'd0,
    CFG_ZOOM_FACTOR   = 3'd1,
    CFG_DEAD_X        = 3'd2,
    CFG_DEAD_Y        = 3'd3,
    CFG_ZOOM_GOAL     = 3'd4,
    CFG_BOUNDS_EN     = 3'd5,
    CFG_BOUNDS_LOW    = 3'd6,
    CFG_BOUNDS_HIGH   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic       load;
    logic       desire;
    logic       mul;
    logic       acc;
    logic [1:0] idx;
    logic       div_start;
    logic       div_h;
    logic       store_w;
    logic       store_h;
    logic       clamp;
    logic       sat;
    logic       out_load;
  } cfs_cmd_t;

  typedef struct packed {
    logic is_setpos;
    logic bounds_en;
    logic div_done;
  } cfs_status_t;

  function automatic logic signed [PosW-1:0] sat32(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = AccW'(32'sh7fff_ffff);
    lo = -AccW'(64'sh8000_0000);
    if (v > hi) return 32'sh7fff_ffff;
    if (v < lo) return 32'sh8000_0000;
    return v[PosW-1:0];
  endfunction

  function automatic logic [WeightW-1:0] weight(input logic [FactorW-1:0] f,
                                                input logic [DtW-1:0] dt);
    logic [FactorW+DtW-1:0] p;
    logic [FactorW+DtW-9:0] s;
    p = f * dt;
    s = p[FactorW+DtW-1:8];
    if (s > {3'b000, ONE_Q16}) return ONE_Q16;
    return s[WeightW-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/cfs_if.sv =====
// ----------------------------------------------------------------------------
// cfs_in_if / cfs_out_if
// Valid/ready channels carrying command words and camera result words.
// ----------------------------------------------------------------------------
`default_nettype none
interface cfs_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] time_step;
  logic        target_present;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  modport source (output valid, command, time_step, target_present, point_x, point_y,
                  point_z, input ready);
  modport sink (input valid, command, time_step, target_present, point_x, point_y,
                point_z, output ready);
endinterface

interface cfs_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] cam_x;
  logic signed [31:0] cam_y;
  logic signed [31:0] cam_z;
  logic [23:0] zoom_now;
  modport source (output valid, cam_x, cam_y, cam_z, zoom_now, input ready);
  modport sink (input valid, cam_x, cam_y, cam_z, zoom_now, output ready);
endinterface
`default_nettype wire

// ===== src/cfs_div.sv =====
// ----------------------------------------------------------------------------
// cfs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module cfs_div (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [cfs_pkg::DvdW-1:0] dividend,
  input  wire logic [cfs_pkg::ZoomW-1:0] divisor,
  output logic done,
  output logic [cfs_pkg::DvdW-1:0] quotient
);
  import cfs_pkg::*;

  localparam int CntW = $clog2(DvdW + 1);

  logic [DvdW-1:0] dvd;
  logic [ZoomW:0] rem;
  logic [CntW-1:0] cnt;
  logic busy;
  logic [ZoomW-1:0] dvs;
  logic [ZoomW:0] rem_sh;
  logic [ZoomW:0] rem_next;
  logic q_bit;

  assign rem_sh = {rem[ZoomW-1:0], dvd[DvdW-1]};
  assign q_bit = (rem_sh >= {1'b0, dvs});
  assign rem_next = q_bit ? rem_sh - {1'b0, dvs} : rem_sh;
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CntW'(DvdW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dvs <= (divisor == '0) ? ZoomW'(1) : divisor;
    end else if (busy) begin
      dvd <= {dvd[DvdW-2:0], q_bit};
      rem <= rem_next;
    end
  end
endmodule
`default_nettype wire

// ===== src/cfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// cfs_ctrl
// Sequencer for one command word and the output handshake.
// ----------------------------------------------------------------------------
`default_nettype none
module cfs_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  input  wire cfs_pkg::cfs_status_t status,
  output cfs_pkg::cfs_cmd_t cmd
);
  import cfs_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_DESIRE = 11'b000_0000_0010,
    S_MUL    = 11'b000_0000_0100,
    S_ACC    = 11'b000_0000_1000,
    S_DWS    = 11'b000_0001_0000,
    S_DWW    = 11'b000_0010_0000,
    S_DHS    = 11'b000_0100_0000,
    S_DHW    = 11'b000_1000_0000,
    S_CLAMP  = 11'b001_0000_0000,
    S_SAT    = 11'b010_0000_0000,
    S_OUT    = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic [1:0] idx;
  logic out_take;

  assign in_ready = (state == S_IDLE);
  assign out_take = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.idx = idx;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DESIRE;
        end
      end
      S_DESIRE: begin
        cmd.desire = 1'b1;
        state_next = status.is_setpos ? S_OUT : S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (idx != 2'd3) state_next = S_MUL;
        else state_next = status.bounds_en ? S_DWS : S_SAT;
      end
      S_DWS: begin
        cmd.div_start = 1'b1;
        state_next = S_DWW;
      end
      S_DWW: begin
        if (status.div_done) begin
          cmd.store_w = 1'b1;
          state_next = S_DHS;
        end
      end
      S_DHS: begin
        cmd.div_start = 1'b1;
        cmd.div_h = 1'b1;
        state_next = S_DHW;
      end
      S_DHW: begin
        if (status.div_done) begin
          cmd.store_h = 1'b1;
          state_next = S_CLAMP;
        end
      end
      S_CLAMP: begin
        cmd.clamp = 1'b1;
        state_next = S_SAT;
      end
      S_SAT: begin
        cmd.sat = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_take) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) idx <= '0;
      else if (cmd.acc) idx <= idx + 1'b1;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ===== src/cfs_dp.sv =====
// ----------------------------------------------------------------------------
// cfs_dp
// Camera state, settings, shared easing multiplier, divider and clamp.
// ----------------------------------------------------------------------------
`default_nettype none
module cfs_dp (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [cfs_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [cfs_pkg::CfgDataW-1:0] cfg_data,
  input  wire logic in_command,
  input  wire logic [15:0] in_time_step,
  input  wire logic in_target_present,
  input  wire logic signed [31:0] in_point_x,
  input  wire logic signed [31:0] in_point_y,
  input  wire logic signed [31:0] in_point_z,
  input  wire cfs_pkg::cfs_cmd_t cmd,
  output cfs_pkg::cfs_status_t status,
  output logic signed [31:0] cam_x,
  output logic signed [31:0] cam_y,
  output logic signed [31:0] cam_z,
  output logic [23:0] zoom_now
);
  import cfs_pkg::*;

  logic [FactorW-1:0] follow_factor;
  logic [FactorW-1:0] zoom_factor;
  logic [DeadW-1:0] dead_x;
  logic [DeadW-1:0] dead_y;
  logic [ZoomW-1:0] zoom_goal;
  logic bounds_en;
  logic [CfgDataW-1:0] bounds_low;
  logic [CfgDataW-1:0] bounds_high;

  logic cmd_r;
  logic tp_r;
  logic [DtW-1:0] dt_r;
  logic signed [PosW-1:0] pt [3];
  logic signed [PosW-1:0] cam [3];
  logic signed [PosW-1:0] des [3];
  logic [ZoomW-1:0] zoom;
  logic [WeightW-1:0] tf;
  logic [WeightW-1:0] tz;
  logic signed [AccW-1:0] acc [3];
  logic signed [51:0] prod;
  logic [DvdW-1:0] hw;
  logic [DvdW-1:0] hh;

  logic div_done;
  logic [DvdW-1:0] quo;
  logic [ZoomW-1:0] zgoal;
  logic [DtW-1:0] dt_cap;

  logic signed [34:0] difx, dify, adx, ady, dx, dy, ox, oy;
  logic dz_on;

  logic signed [33:0] e_goal, e_cur;
  logic signed [33:0] e_diff;
  logic [WeightW-1:0] e_t;
  logic signed [AccW-1:0] e_sum;
  logic signed [AccW-1:0] lx, ly, hx, hy, lo_x, hi_x, lo_y, hi_y;

  cfs_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .dividend(cmd.div_h ? DVD_HALF_H : DVD_HALF_W),
    .divisor(zoom), .done(div_done), .quotient(quo)
  );

  assign status.is_setpos = cmd_r;
  assign status.bounds_en = bounds_en;
  assign status.div_done = div_done;

  assign zgoal = (zoom_goal < ZOOM_FLOOR) ? ZOOM_FLOOR : zoom_goal;
  assign dt_cap = (in_time_step > {4'd0, DT_CAP}) ? DT_CAP : in_time_step[DtW-1:0];

  // dead zone
  assign dz_on = (dead_x != '0) || (dead_y != '0);
  assign difx = 35'(pt[0]) - 35'(cam[0]);
  assign dify = 35'(pt[1]) - 35'(cam[1]);
  assign adx = difx[34] ? -difx : difx;
  assign ady = dify[34] ? -dify : dify;
  assign dx = adx - $signed({4'd0, dead_x});
  assign dy = ady - $signed({4'd0, dead_y});
  assign ox = (dx > 0) ? ((difx > 0) ? dx : -dx) : '0;
  assign oy = (dy > 0) ? ((dify > 0) ? dy : -dy) : '0;

  // easing operands
  always_comb begin
    if (cmd.idx == 2'd3) begin
      e_goal = $signed({10'd0, zgoal});
      e_cur = $signed({10'd0, zoom});
      e_t = tz;
    end else begin
      e_goal = 34'(des[cmd.idx]);
      e_cur = 34'(cam[cmd.idx]);
      e_t = tf;
    end
  end
  assign e_diff = e_goal - e_cur;
  assign e_sum = AccW'(e_cur) + AccW'(prod >>> 16);

  assign lx = AccW'($signed(bounds_low[31:0]));
  assign ly = AccW'($signed(bounds_low[63:32]));
  assign hx = AccW'($signed(bounds_high[31:0]));
  assign hy = AccW'($signed(bounds_high[63:32]));
  assign lo_x = lx + $signed({3'd0, hw});
  assign hi_x = hx - $signed({3'd0, hw});
  assign lo_y = ly + $signed({3'd0, hh});
  assign hi_y = hy - $signed({3'd0, hh});

  always_ff @(posedge clk) begin
    if (rst) begin
      follow_factor <= '0;
      zoom_factor <= ZOOM_FACTOR_RESET;
      dead_x <= '0;
      dead_y <= '0;
      zoom_goal <= ZOOM_RESET;
      bounds_en <= 1'b0;
      bounds_low <= '0;
      bounds_high <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FOLLOW_FACTOR: follow_factor <= cfg_data[FactorW-1:0];
        CFG_ZOOM_FACTOR:   zoom_factor <= cfg_data[FactorW-1:0];
        CFG_DEAD_X:        dead_x <= cfg_data[DeadW-1:0];
        CFG_DEAD_Y:        dead_y <= cfg_data[DeadW-1:0];
        CFG_ZOOM_GOAL:     zoom_goal <= cfg_data[ZoomW-1:0];
        CFG_BOUNDS_EN:     bounds_en <= cfg_data[0];
        CFG_BOUNDS_LOW:    bounds_low <= cfg_data;
        CFG_BOUNDS_HIGH:   bounds_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        cam[i] <= '0;
        des[i] <= '0;
      end
      zoom <= ZOOM_RESET;
    end else begin
      if (cmd.desire) begin
        if (cmd_r) begin
          for (int i = 0; i < 3; i++) begin
            cam[i] <= pt[i];
            des[i] <= pt[i];
          end
        end else if (tp_r) begin
          if (!dz_on) begin
            for (int i = 0; i < 3; i++) des[i] <= pt[i];
          end else if ((dx > 0) || (dy > 0)) begin
            des[0] <= sat32(AccW'(cam[0]) + AccW'(ox));
            des[1] <= sat32(AccW'(cam[1]) + AccW'(oy));
            des[2] <= cam[2];
          end
        end
      end
      if (cmd.acc && (cmd.idx == 2'd3)) begin
        if (e_sum < 0) zoom <= '0;
        else if (e_sum > AccW'(24'hff_ffff)) zoom <= 24'hff_ffff;
        else zoom <= e_sum[ZoomW-1:0];
      end
      if (cmd.sat) begin
        for (int i = 0; i < 3; i++) cam[i] <= sat32(acc[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_command;
      tp_r <= in_target_present;
      dt_r <= dt_cap;
      pt[0] <= in_point_x;
      pt[1] <= in_point_y;
      pt[2] <= in_point_z;
    end
    if (cmd.desire) begin
      tf <= (follow_factor == '0) ? ONE_Q16 : weight(follow_factor, dt_r);
      tz <= weight(zoom_factor, dt_r);
    end
    if (cmd.mul) prod <= e_diff * $signed({1'b0, e_t});
    if (cmd.acc && (cmd.idx != 2'd3)) acc[cmd.idx] <= e_sum;
    if (cmd.store_w) hw <= quo;
    if (cmd.store_h) hh <= quo;
    if (cmd.clamp) begin
      if (acc[0] > hi_x) acc[0] <= (hi_x < lo_x) ? lo_x : hi_x;
      else if (acc[0] < lo_x) acc[0] <= lo_x;
      if (acc[1] > hi_y) acc[1] <= (hi_y < lo_y) ? lo_y : hi_y;
      else if (acc[1] < lo_y) acc[1] <= lo_y;
    end
    if (cmd.out_load) begin
      cam_x <= cam[0];
      cam_y <= cam[1];
      cam_z <= cam[2];
      zoom_now <= zoom;
    end
  end
endmodule
`default_nettype wire

// ===== src/camera_follow_smoother.sv =====
// ----------------------------------------------------------------------------
// camera_follow_smoother
// Follow camera with dead zone, exponential easing of position and zoom,
// and optional bounds clamping.
//
//   channel  dir  contents
//   in       in   command, time_step, target_present, point_x/y/z
//   out      out  cam_x, cam_y, cam_z, zoom_now
//   cfg      in   cfg_we, cfg_index, cfg_data
//
// a set position skips the easing; with bounds enabled a tick adds two
// serial divisions for the margins, and these dominate its time.
// easing shares one multiplier over four passes (x, y, z, zoom).
// one word in flight; a finished word waits in the output register.
// synchronous active-high reset restores the camera, zoom and settings.
// ----------------------------------------------------------------------------
`default_nettype none
module camera_follow_smoother (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [cfs_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [cfs_pkg::CfgDataW-1:0] cfg_data,
  cfs_in_if.sink in,
  cfs_out_if.source out
);
  import cfs_pkg::*;

  cfs_cmd_t cmd;
  cfs_status_t status;

  cfs_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in.valid), .in_ready(in.ready),
    .out_valid(out.valid), .out_ready(out.ready),
    .status(status), .cmd(cmd)
  );

  cfs_dp u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_command(in.command), .in_time_step(in.time_step),
    .in_target_present(in.target_present),
    .in_point_x(in.point_x), .in_point_y(in.point_y), .in_point_z(in.point_z),
    .cmd(cmd), .status(status),
    .cam_x(out.cam_x), .cam_y(out.cam_y), .cam_z(out.cam_z),
    .zoom_now(out.zoom_now)
  );
endmodule
`default_nettype wire
